// File: rtl/ird_pkg.sv
// Shared constants, types, microcode table and digit encoding for the radix digit converter.
package ird_pkg;

    // Sizing
    localparam int MAX_DIGITS = 32;
    localparam int MAX_BASE   = 36;
    localparam int RESULT_CAP = 31;
    localparam int CAP        = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;

    localparam int NUM_W = 32;
    localparam int Q_W   = NUM_W - 1;
    localparam int BASE_W = 8;
    localparam int DIV_W = $clog2(MAX_BASE + 1);
    localparam int DIG_W = $clog2(MAX_BASE);
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CHAR_W = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;
    localparam int DEC_DIGITS = 10;

    // Microcode fields
    localparam int PC_W = 4;
    localparam int OP_W = 3;
    localparam int HOLD_W = 2;
    localparam int COND_W = 3;

    localparam logic [OP_W-1:0] OP_NOP        = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV_START  = 3'd2;
    localparam logic [OP_W-1:0] OP_STORE      = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_SETUP   = 3'd4;
    localparam logic [OP_W-1:0] OP_EMIT_DIG   = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT_ERR   = 3'd6;
    localparam logic [OP_W-1:0] OP_EMIT_EMPTY = 3'd7;

    localparam logic [HOLD_W-1:0] HOLD_NONE = 2'd0;
    localparam logic [HOLD_W-1:0] HOLD_IN   = 2'd1;
    localparam logic [HOLD_W-1:0] HOLD_OUT  = 2'd2;
    localparam logic [HOLD_W-1:0] HOLD_DIV  = 2'd3;

    localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] COND_BAD_BASE = 3'd2;
    localparam logic [COND_W-1:0] COND_NONPOS   = 3'd3;
    localparam logic [COND_W-1:0] COND_QUOT_NZ  = 3'd4;
    localparam logic [COND_W-1:0] COND_IDX_NZ   = 3'd5;

    // Microprogram addresses
    localparam logic [PC_W-1:0] UPC_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] UPC_CHK_BASE  = 4'd1;
    localparam logic [PC_W-1:0] UPC_CHK_SIGN  = 4'd2;
    localparam logic [PC_W-1:0] UPC_DIV_START = 4'd3;
    localparam logic [PC_W-1:0] UPC_DIV_STORE = 4'd4;
    localparam logic [PC_W-1:0] UPC_RD_SETUP  = 4'd5;
    localparam logic [PC_W-1:0] UPC_EMIT      = 4'd6;
    localparam logic [PC_W-1:0] UPC_RETURN    = 4'd7;
    localparam logic [PC_W-1:0] UPC_ERR       = 4'd8;
    localparam logic [PC_W-1:0] UPC_EMPTY     = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HOLD_W-1:0] hold;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ucw_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // The microprogram. A step repeats while its hold condition is unmet; once met,
    // the step's operation takes effect and control jumps to target if cond holds.
    function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        w.op     = OP_NOP;
        w.hold   = HOLD_NONE;
        w.cond   = COND_ALWAYS;
        w.target = UPC_IDLE;
        unique case (pc)
            UPC_IDLE: begin
                w.op   = OP_LOAD;
                w.hold = HOLD_IN;
                w.cond = COND_NEVER;
            end
            UPC_CHK_BASE: begin
                w.cond   = COND_BAD_BASE;
                w.target = UPC_ERR;
            end
            UPC_CHK_SIGN: begin
                w.cond   = COND_NONPOS;
                w.target = UPC_EMPTY;
            end
            UPC_DIV_START: begin
                w.op   = OP_DIV_START;
                w.cond = COND_NEVER;
            end
            UPC_DIV_STORE: begin
                w.op     = OP_STORE;
                w.hold   = HOLD_DIV;
                w.cond   = COND_QUOT_NZ;
                w.target = UPC_DIV_START;
            end
            UPC_RD_SETUP: begin
                w.op   = OP_RD_SETUP;
                w.cond = COND_NEVER;
            end
            UPC_EMIT: begin
                w.op     = OP_EMIT_DIG;
                w.hold   = HOLD_OUT;
                w.cond   = COND_IDX_NZ;
                w.target = UPC_EMIT;
            end
            UPC_ERR: begin
                w.op   = OP_EMIT_ERR;
                w.hold = HOLD_OUT;
            end
            UPC_EMPTY: begin
                w.op   = OP_EMIT_EMPTY;
                w.hold = HOLD_OUT;
            end
            default: begin
                w.cond = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

    // Digit value to upper-case ASCII.
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] dv;
        dv = CHAR_W'(d);
        if (dv < CHAR_W'(DEC_DIGITS)) begin
            return CHAR_ZERO + dv;
        end
        return CHAR_ALPHA + (dv - CHAR_W'(DEC_DIGITS));
    endfunction

endpackage

// File: rtl/integer_to_radix_digits.sv
// Top level of the integer to radix digit string converter with its microcoded sequencer.
//
// The block takes a signed 32-bit number and an 8-bit base in one transfer on the s_
// channel and returns the number's digits in that base as upper-case ASCII characters,
// most significant first, one transfer per digit on the m_ channel, with m_last on the
// final one. A base outside 2..36 gives a single transfer with m_bad_base set, and a
// number of zero or below (with a good base) gives a single transfer with m_empty_res
// set; both carry character code zero and m_last. Items are handled one at a time. A short
// microprogram held in a constant table steps the datapath: it checks the base and sign,
// then runs one division per digit on a restoring divider that yields one quotient bit
// per cycle; each digit takes a start step, the divider's run and a store step, and
// the remainders go into a small digit store. The digits are then read back in reverse
// order, one per cycle while the output side keeps taking them. The result register
// lets the next item be taken while the last result of the previous one still waits.
// The digit store needs no clearing after reset.
module integer_to_radix_digits (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [ird_pkg::NUM_W-1:0] s_number,
    input  logic [ird_pkg::BASE_W-1:0]     s_base,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ird_pkg::CHAR_W-1:0]     m_digit_char,
    output logic                           m_last,
    output logic                           m_empty_res,
    output logic                           m_bad_base
);
    import ird_pkg::*;

    // Sequencer
    logic [PC_W-1:0]   pc_reg, pc_next;
    ucw_t              cw;
    logic              hold_met;
    logic              cond_true;

    // Datapath registers
    logic [Q_W-1:0]    wq_reg;
    logic              sign_reg;
    logic [BASE_W-1:0] base_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  idx_reg;
    logic              bad_base;
    logic              nonpos;

    // Digit store
    logic [DIG_W-1:0]  store_mem [MAX_DIGITS];
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DIG_W-1:0]  rd_data_reg;

    // Divider
    logic              div_start;
    div_status_t       div_status;
    logic [Q_W-1:0]    div_quot;
    logic [DIV_W-1:0]  div_rem;

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_digit_char_reg;
    logic              m_last_reg;
    logic              m_empty_res_reg;
    logic              m_bad_base_reg;
    logic              out_free;
    logic              out_load;

    assign cw       = ucode(pc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign bad_base = (base_reg < BASE_W'(2)) || (base_reg > BASE_W'(MAX_BASE));
    assign nonpos   = sign_reg || (wq_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);

    // A step only takes effect once the resource it waits on is there.
    always_comb begin
        unique case (cw.hold)
            HOLD_NONE: hold_met = 1'b1;
            HOLD_IN:   hold_met = s_valid;
            HOLD_OUT:  hold_met = out_free;
            HOLD_DIV:  hold_met = div_status.done;
            default:   hold_met = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_BAD_BASE: cond_true = bad_base;
            COND_NONPOS:   cond_true = nonpos;
            COND_QUOT_NZ:  cond_true = (div_quot != '0);
            COND_IDX_NZ:   cond_true = (idx_reg != '0);
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (!hold_met) begin
            pc_next = pc_reg;
        end else if (cond_true) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    assign s_ready   = (cw.hold == HOLD_IN);
    assign div_start = hold_met && (cw.op == OP_DIV_START);

    // Remainders beyond the store's capacity are dropped; only the low digits are kept.
    assign wr_en   = hold_met && (cw.op == OP_STORE) && (count_reg < CNT_W'(CAP));
    assign wr_addr = IDX_W'(count_reg);

    // Read-back runs one entry ahead: the emit step fetches the next lower digit on
    // the same edge that it loads the current one into the result register.
    assign rd_en   = hold_met && ((cw.op == OP_RD_SETUP) || (cw.op == OP_EMIT_DIG));
    assign rd_addr = (cw.op == OP_RD_SETUP) ? IDX_W'(count_m1) : idx_reg - IDX_W'(1);

    assign out_load = hold_met && ((cw.op == OP_EMIT_DIG) || (cw.op == OP_EMIT_ERR) ||
                                   (cw.op == OP_EMIT_EMPTY));

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    ird_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (wq_reg),
        .divisor   (DIV_W'(base_reg)),
        .status    (div_status),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= UPC_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            if (hold_met && (cw.op == OP_LOAD)) begin
                count_reg <= '0;
            end else if (wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_met) begin
            case (cw.op)
                OP_LOAD: begin
                    wq_reg   <= s_number[Q_W-1:0];
                    sign_reg <= s_number[NUM_W-1];
                    base_reg <= s_base;
                end
                OP_STORE: begin
                    wq_reg <= div_quot;
                end
                OP_RD_SETUP: begin
                    idx_reg <= IDX_W'(count_m1);
                end
                OP_EMIT_DIG: begin
                    idx_reg <= idx_reg - IDX_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            case (cw.op)
                OP_EMIT_DIG: begin
                    m_digit_char_reg <= digit_ascii(rd_data_reg);
                    m_last_reg       <= (idx_reg == '0);
                    m_empty_res_reg  <= 1'b0;
                    m_bad_base_reg   <= 1'b0;
                end
                OP_EMIT_ERR: begin
                    m_digit_char_reg <= '0;
                    m_last_reg       <= 1'b1;
                    m_empty_res_reg  <= 1'b0;
                    m_bad_base_reg   <= 1'b1;
                end
                default: begin
                    m_digit_char_reg <= '0;
                    m_last_reg       <= 1'b1;
                    m_empty_res_reg  <= 1'b1;
                    m_bad_base_reg   <= 1'b0;
                end
            endcase
        end
    end

    // Digit store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= DIG_W'(div_rem);
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_digit_char_reg;
    assign m_last       = m_last_reg;
    assign m_empty_res  = m_empty_res_reg;
    assign m_bad_base   = m_bad_base_reg;

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (count_reg < CNT_W'(CAP)))
        else $error("digit store written beyond its capacity");

    a_no_take_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !s_ready)
        else $error("new item taken while a digit run is still being delivered");

    a_div_base_good: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> ((base_reg >= BASE_W'(2)) && (base_reg <= BASE_W'(MAX_BASE))))
        else $error("division started with a base outside the legal range");

    a_flag_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_empty_res || m_bad_base)) |-> (m_last && (m_digit_char == '0)))
        else $error("flagged result is not a single character-free transfer");

endmodule

// File: rtl/ird_divider.sv
// Restoring divider of the working quotient by the base, one quotient bit per cycle.
module ird_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ird_pkg::Q_W-1:0]    dividend,
    input  logic [ird_pkg::DIV_W-1:0]  divisor,
    output ird_pkg::div_status_t       status,
    output logic [ird_pkg::Q_W-1:0]    quotient,
    output logic [ird_pkg::DIV_W-1:0]  remainder
);
    import ird_pkg::*;

    localparam int STEP_W = $clog2(Q_W);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(Q_W - 1);

    logic [Q_W-1:0]    q_reg, q_next;
    logic [DIV_W-1:0]  r_reg, r_next;
    logic [DIV_W-1:0]  d_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              ge;

    assign trial = {r_reg, q_reg[Q_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            q_next = {q_reg[Q_W-2:0], ge};
            r_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg    <= divisor;
            step_reg <= STEP_FIRST;
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;
    assign remainder   = r_reg;

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while a division was in progress");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider finished without having run");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench that converts numbers to radix digit strings and checks every character.
module testbench;
    import ird_pkg::*;

    // Reset length, the watchdog limit and the quiet time after the last transfer.
    // The slowest legal item (the largest number in base 2) gives the longest spell
    // that the block spends without a transfer. The watchdog limit allows many times
    // that, plus the longest stall the receiver is ever likely to produce.
    localparam int RESET_CYCLES     = 7;
    localparam int STALL_LIMIT      = 20000;
    localparam int DRAIN_CYCLES     = 100;
    localparam int RANDOM_PER_PHASE = 60;
    localparam int NUM_PHASES       = 3;

    typedef struct packed {
        logic signed [NUM_W-1:0] number;
        logic [BASE_W-1:0]       radix;
    } conversion_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              empty_res;
        logic              bad_base;
    } char_result_t;

    // Every input of the block holds a known value from time zero onwards.
    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_valid  = 1'b0;
    logic                    s_ready;
    logic signed [NUM_W-1:0] s_number = '0;
    logic [BASE_W-1:0]       s_base   = '0;
    logic                    m_valid;
    logic                    m_ready  = 1'b0;
    logic [CHAR_W-1:0]       m_digit_char;
    logic                    m_last;
    logic                    m_empty_res;
    logic                    m_bad_base;

    // Requests waiting for the driver, and the characters still owed by the block.
    conversion_req_t pending_requests[$];
    char_result_t    expected_chars[$];

    // Percentage of cycles in which each side holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int numbers_sent   = 0;
    int chars_received = 0;
    int bad_base_seen  = 0;
    int empty_seen     = 0;
    int longest_string = 0;
    int error_count    = 0;
    int stall_cycles   = 0;

    integer_to_radix_digits u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_number     (s_number),
        .s_base       (s_base),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last       (m_last),
        .m_empty_res  (m_empty_res),
        .m_bad_base   (m_bad_base)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Works out the characters that one accepted request must produce and queues them.
    // A bad base is checked before the sign, so it wins over a non-positive number.
    // Otherwise the number is divided down, remainders collected least significant
    // first, and the characters are queued most significant first.
    function automatic void predict_conversion(input conversion_req_t req);
        logic [DIG_W-1:0] remainders [CAP];
        logic [Q_W-1:0]   quotient;
        char_result_t     r;
        int               n;
        int               k;
        n = 0;
        r = '0;
        if (req.radix < 2 || req.radix > MAX_BASE) begin
            r.last     = 1'b1;
            r.bad_base = 1'b1;
            expected_chars.push_back(r);
            bad_base_seen++;
        end else if (req.number[NUM_W-1] || req.number == 0) begin
            r.last      = 1'b1;
            r.empty_res = 1'b1;
            expected_chars.push_back(r);
            empty_seen++;
        end else begin
            quotient = req.number[Q_W-1:0];
            while (quotient != 0) begin
                // Digits beyond the store's capacity are the more significant ones
                // and are dropped; at the default sizes this never happens.
                if (n < CAP) begin
                    remainders[n] = DIG_W'(quotient % req.radix);
                    n++;
                end
                quotient = quotient / req.radix;
            end
            for (k = n - 1; k >= 0; k--) begin
                if (remainders[k] < DEC_DIGITS) begin
                    r.digit_char = CHAR_ZERO + CHAR_W'(remainders[k]);
                end else begin
                    r.digit_char = CHAR_ALPHA + CHAR_W'(remainders[k]) - CHAR_W'(DEC_DIGITS);
                end
                r.last = (k == 0);
                expected_chars.push_back(r);
            end
            if (n > longest_string) begin
                longest_string = n;
            end
        end
    endfunction

    // Most random requests are well-formed positive numbers with a good base, of
    // random bit length so that strings of every length turn up; a quarter of
    // them use the smallest bases to get the longest strings. The rest are bad
    // bases (low and high) and non-positive numbers, including zero.
    function automatic conversion_req_t random_request();
        conversion_req_t req;
        int              pick;
        int              width;
        pick       = $urandom_range(99);
        req.number = $urandom;
        if (pick < 10) begin
            if ($urandom_range(3) == 0) begin
                req.radix = BASE_W'($urandom_range(1, 0));
            end else begin
                req.radix = BASE_W'($urandom_range(255, MAX_BASE + 1));
            end
        end else if (pick < 20) begin
            req.radix = BASE_W'($urandom_range(MAX_BASE, 2));
            if ($urandom_range(2) == 0) begin
                req.number = '0;
            end else begin
                req.number[NUM_W-1] = 1'b1;
            end
        end else begin
            if ($urandom_range(3) == 0) begin
                req.radix = BASE_W'($urandom_range(4, 2));
            end else begin
                req.radix = BASE_W'($urandom_range(MAX_BASE, 2));
            end
            width      = $urandom_range(Q_W, 1);
            req.number = req.number & ((32'h1 << width) - 1);
            if (req.number == 0) begin
                req.number = 1;
            end
        end
        return req;
    endfunction

    task automatic queue_request(input logic [NUM_W-1:0] number, input logic [BASE_W-1:0] radix);
        conversion_req_t req;
        req.number = number;
        req.radix  = radix;
        pending_requests.push_back(req);
    endtask

    task automatic check_field(input string field, input logic [CHAR_W-1:0] want,
                               input logic [CHAR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Driver. A request is offered only when the channel is free, and once offered
    // it is held, payload unchanged, until the transfer completes. Each completed
    // transfer is handed to the predictor at the edge on which it happens.
    always @(posedge aclk) begin : drive_requests
        conversion_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                req.number = s_number;
                req.radix  = s_base;
                predict_conversion(req);
                numbers_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    s_number <= req.number;
                    s_base   <= req.radix;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every character transfer is matched against the oldest expectation,
    // field by field; a transfer with nothing expected is an error in itself.
    always @(posedge aclk) begin : check_results
        char_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                chars_received++;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected transfer: expected none, actual char %0h last %b",
                             $time, m_digit_char, m_last);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    check_field("digit_char", want.digit_char, m_digit_char);
                    check_field("last", CHAR_W'(want.last), CHAR_W'(m_last));
                    check_field("empty_res", CHAR_W'(want.empty_res), CHAR_W'(m_empty_res));
                    check_field("bad_base", CHAR_W'(want.bad_base), CHAR_W'(m_bad_base));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a long spell without a transfer on either channel means the block
    // has hung, so the run is ended there.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus and phase control. Each phase sets how often the two sides idle,
    // fills the request queue and then waits until every character owed has come
    // back, so the sender sits idle on an empty block between phases.
    initial begin : run_phases
        int phase;
        int i;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: the widest positive number in the smallest, a decimal
        // and the largest base, single-character strings at both ends of the
        // alphabet, zero and negative numbers, bad bases on either side of the
        // legal range, and a bad base winning over a non-positive number.
        queue_request(32'h7FFF_FFFF, 8'd2);
        queue_request(32'h7FFF_FFFF, 8'd36);
        queue_request(32'h7FFF_FFFF, 8'd10);
        queue_request(32'h0000_0001, 8'd2);
        queue_request(32'd35, 8'd36);
        queue_request(32'd10, 8'd11);
        queue_request(32'd20, 8'd36);
        queue_request(32'd36, 8'd36);
        queue_request(32'd255, 8'd16);
        queue_request(32'h4000_0000, 8'd2);
        queue_request(32'h5555_5555, 8'd2);
        queue_request(32'd123456789, 8'd3);
        queue_request(32'h0000_0000, 8'd10);
        queue_request(32'hFFFF_FFFF, 8'd10);
        queue_request(32'h8000_0000, 8'd16);
        queue_request(32'd5, 8'd0);
        queue_request(32'd5, 8'd1);
        queue_request(32'd5, 8'd37);
        queue_request(32'd5, 8'd255);
        queue_request(32'hFFFF_FFFF, 8'd255);
        queue_request(32'h0000_0000, 8'd0);
        queue_request(32'h8000_0000, 8'd1);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (i = 0; i < RANDOM_PER_PHASE; i++) begin
                pending_requests.push_back(random_request());
            end
            while (pending_requests.size() != 0 || s_valid || expected_chars.size() != 0) begin
                @(posedge aclk);
            end
        end

        // Give the block time to show any stray transfer after the last character.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d numbers converted into %0d characters, longest string %0d digits.",
                 numbers_sent, chars_received, longest_string);
        $display("Summary: %0d bad-base and %0d empty cases, %0d mismatches.",
                 bad_base_seen, empty_seen, error_count);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
